@@ design/dcm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the DC motor step block: payload structs, register indexes, opcodes.
// No dependencies.
package dcm_pkg;
    typedef struct packed {
        logic        opcode;
        logic [31:0] drive_current;
        logic [47:0] new_position;
        logic [31:0] new_velocity;
        logic [31:0] new_acceleration;
    } req_t;

    typedef struct packed {
        logic [47:0] position;
        logic [31:0] velocity;
        logic [31:0] acceleration;
        logic        held_by_friction;
    } rsp_t;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    localparam logic [2:0] REG_CURRENT_GAIN  = 3'd0;
    localparam logic [2:0] REG_LOAD_TORQUE   = 3'd1;
    localparam logic [2:0] REG_STATIC_FRIC   = 3'd2;
    localparam logic [2:0] REG_SLIDING_FRIC  = 3'd3;
    localparam logic [2:0] REG_CYCLE_TIME    = 3'd4;
    localparam logic [2:0] REG_DECAY_FACTOR  = 3'd5;
    localparam logic [2:0] REG_POSITION_GAIN = 3'd6;
    localparam logic [2:0] REG_ACCEL_GAIN    = 3'd7;

    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;
endpackage

@@ design/dcm_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial signed multiplier, one multiplier bit per cycle (shift and add).
// Depends on dcm_pkg for operand widths.
module dcm_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [dcm_pkg::MUL_W-1:0] a,
    input  logic signed [dcm_pkg::MUL_W-1:0] b,
    output logic                          done,
    output logic signed [dcm_pkg::PROD_W-1:0] prod
);
    localparam int W = dcm_pkg::MUL_W;
    localparam int PW = dcm_pkg::PROD_W;

    logic busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mcand_reg, mcand_next;
    logic [W-1:0] mplier_reg, mplier_next;
    logic done_reg, done_next;

    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            mcand_next = PW'(a);
            mplier_next = b;
        end else if (busy_reg) begin
            // last bit is the sign bit: subtract
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'(W - 1)) acc_next = acc_reg - mcand_reg;
                else acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

@@ design/dc_motor_current_drive_sim_step.sv @@
`timescale 1ns / 1ps
// Top level of the current-driven DC motor step emulator.
// Depends on dcm_pkg and dcm_mul.
//
// One request advances the motor state by one period (opcode advance) or
// loads it (opcode load). A load shows its result the cycle after acceptance.
// An advance runs five products through one bit-serial 34x34 multiplier
// in turn; a stopped shaft held by friction finishes after the first product.
// One request at a time: the input stays blocked while a request runs and
// while its result waits, and the next request can be accepted in the cycle
// after the result is taken.
module dc_motor_current_drive_sim_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  dcm_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output dcm_pkg::rsp_t m_data
);
    localparam int W = dcm_pkg::MUL_W;
    localparam int PW = dcm_pkg::PROD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRIVE = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic signed [31:0] current_gain_reg, load_torque_reg;
    logic [30:0] static_fric_reg, sliding_fric_reg, cycle_time_reg;
    logic [16:0] decay_reg;
    logic [30:0] pos_gain_reg, accel_gain_reg;

    logic signed [47:0] angle_reg;
    logic signed [31:0] speed_reg, accel_reg;

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic signed [31:0] cur_reg;
    logic signed [32:0] r_reg;
    logic signed [33:0] c_reg;
    logic signed [47:0] asum_reg;
    logic out_valid_reg;
    dcm_pkg::rsp_t out_reg;

    logic mul_start, mul_done;
    logic signed [W-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] rnd;

    dcm_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_p)
    );

    assign rnd = (mul_p + PW'(32768)) >>> 16;

    // operand select per step: 0 drive, 1 r*T, 2 c*pg, 3 c*decay, 4 -c*ag
    always_comb begin
        unique case (step_reg)
            3'd0: begin mul_a = W'(cur_reg); mul_b = W'(current_gain_reg); end
            3'd1: begin mul_a = W'(r_reg); mul_b = W'({1'b0, cycle_time_reg}); end
            3'd2: begin mul_a = c_reg; mul_b = W'({1'b0, pos_gain_reg}); end
            3'd3: begin mul_a = c_reg; mul_b = W'({1'b0, decay_reg}); end
            3'd4: begin mul_a = -c_reg; mul_b = W'({1'b0, accel_gain_reg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
        if (x > PW'(64'sd2147483647)) return 32'sh7fffffff;
        if (x < -PW'(64'sd2147483648)) return 32'sh80000000;
        return x[31:0];
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    logic signed [PW-1:0] drive_w, f_w, r_w;
    always_comb begin
        drive_w = PW'(sat32(rnd - PW'(load_torque_reg)));
        f_w = (speed_reg == 0) ? PW'({1'b0, static_fric_reg})
                               : PW'({1'b0, sliding_fric_reg});
        if (drive_w > f_w) r_w = drive_w - f_w;
        else if (drive_w < -f_w) r_w = drive_w + f_w;
        else r_w = '0;
    end

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready && s_data.opcode == dcm_pkg::OP_ADVANCE) begin
                state_next = ST_DRIVE;
                step_next = 3'd0;
            end
            ST_DRIVE: begin mul_start = 1'b1; state_next = ST_WAIT; end
            ST_MUL: begin mul_start = 1'b1; state_next = ST_WAIT; end
            ST_WAIT: if (mul_done) begin
                if (step_reg == 3'd0 && r_w == 0 && speed_reg == 0) state_next = ST_DONE;
                else if (step_reg == 3'd4) state_next = ST_DONE;
                else begin step_next = step_reg + 3'd1; state_next = ST_MUL; end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_gain_reg <= 32'sd65536;
            load_torque_reg <= '0;
            static_fric_reg <= '0;
            sliding_fric_reg <= '0;
            cycle_time_reg <= 31'd65;
            decay_reg <= 17'd65536;
            pos_gain_reg <= '0;
            accel_gain_reg <= '0;
            angle_reg <= '0;
            speed_reg <= '0;
            accel_reg <= '0;
            state_reg <= ST_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    dcm_pkg::REG_CURRENT_GAIN:  current_gain_reg <= cfg_data;
                    dcm_pkg::REG_LOAD_TORQUE:   load_torque_reg <= cfg_data;
                    dcm_pkg::REG_STATIC_FRIC:   static_fric_reg <= cfg_data[30:0];
                    dcm_pkg::REG_SLIDING_FRIC:  sliding_fric_reg <= cfg_data[30:0];
                    dcm_pkg::REG_CYCLE_TIME:    cycle_time_reg <= cfg_data[30:0];
                    dcm_pkg::REG_DECAY_FACTOR:  decay_reg <= cfg_data[16:0];
                    dcm_pkg::REG_POSITION_GAIN: pos_gain_reg <= cfg_data[30:0];
                    dcm_pkg::REG_ACCEL_GAIN:    accel_gain_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (s_valid && s_ready) begin
                if (s_data.opcode == dcm_pkg::OP_LOAD) begin
                    angle_reg <= s_data.new_position;
                    speed_reg <= s_data.new_velocity;
                    accel_reg <= s_data.new_acceleration;
                    out_reg.position <= s_data.new_position;
                    out_reg.velocity <= s_data.new_velocity;
                    out_reg.acceleration <= s_data.new_acceleration;
                    out_reg.held_by_friction <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
            end
            if (state_reg == ST_WAIT && mul_done) begin
                unique case (step_reg)
                    3'd0: begin
                        r_reg <= r_w[32:0];
                        c_reg <= 34'(speed_reg) - r_w[33:0];
                        asum_reg <= angle_reg;
                        if (r_w == 0 && speed_reg == 0) begin
                            speed_reg <= '0;
                            accel_reg <= '0;
                            out_reg.position <= angle_reg;
                            out_reg.velocity <= '0;
                            out_reg.acceleration <= '0;
                            out_reg.held_by_friction <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    3'd1, 3'd2: asum_reg <= asum_reg + rnd[47:0];
                    3'd3: speed_reg <= sat32(PW'(r_reg) + rnd);
                    3'd4: begin
                        accel_reg <= sat32(rnd);
                        angle_reg <= asum_reg;
                        out_reg.position <= asum_reg;
                        out_reg.velocity <= speed_reg;
                        out_reg.acceleration <= sat32(rnd);
                        out_reg.held_by_friction <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) cur_reg <= s_data.drive_current;
    end
endmodule
